// ===== src/lbr_pkg.sv =====
package lbr_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned SHIFT_W  = 4;
    localparam int unsigned LEN_W    = 6;
    localparam int unsigned CNT_W    = 5;

    localparam logic [WORD_W-1:0] TAP_MASK  = 32'hd000_0001;
    localparam logic [WORD_W-1:0] MIN_BOUND = 32'd2;
    localparam logic              FUNC_DRAW = 1'b0;
    localparam logic              FUNC_LOAD = 1'b1;
    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(WORD_W - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_seed;
        logic clear_value;
        logic start_draw;
        logic prep;
        logic div_step;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_load;
        logic is_small;
        logic div_last;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] lfsr_advance(input logic [WORD_W-1:0] s);
        logic [WORD_W-1:0] fb;
        fb = s[0] ? TAP_MASK : '0;
        return (s >> 1) ^ fb;
    endfunction

    function automatic logic [SHIFT_W-1:0] shift_of(input logic [WORD_W-1:0] v);
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] diff;
        len = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                len = LEN_W'(i + 1);
            end
        end
        diff = LEN_W'(WORD_W) - len;
        return diff[SHIFT_W:1];
    endfunction

endpackage

// ===== src/lbr_ctrl.sv =====
module lbr_ctrl
    import lbr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output logic     o_out_valid,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_stat.is_load) begin
                        o_cmd.load_seed   = 1'b1;
                        o_cmd.clear_value = 1'b1;
                        n_state           = S_DONE;
                    end else if (i_stat.is_small) begin
                        o_cmd.clear_value = 1'b1;
                        n_state           = S_DONE;
                    end else begin
                        o_cmd.start_draw = 1'b1;
                        n_state          = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_stat.div_last) |=> (r_state == S_DONE))
        else $error("divider finished but result not presented");

    a_draw_preps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_draw |=> o_cmd.prep)
        else $error("draw started without dividend setup");

endmodule

// ===== src/lbr_dp.sv =====
module lbr_dp
    import lbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_func,
    input  logic [WORD_W-1:0] i_range_max,
    input  logic [WORD_W-1:0] i_seed_value,
    output t_dp_stat          o_stat,
    output logic [WORD_W-1:0] o_value,
    output logic [WORD_W-1:0] o_seed_now
);

    logic [WORD_W-1:0]  r_lfsr;
    logic [WORD_W-1:0]  r_bound;
    logic [SHIFT_W-1:0] r_shift;
    logic [WORD_W-1:0]  r_quo;
    logic [WORD_W-1:0]  r_rem;
    logic [CNT_W-1:0]   r_cnt;

    logic [WORD_W:0]    n_trial;
    logic [WORD_W:0]    n_diff;

    always_comb begin
        n_trial = {r_rem, r_quo[WORD_W-1]};
        n_diff  = n_trial - {1'b0, r_bound};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= WORD_W'(1);
        end else if (i_cmd.load_seed) begin
            r_lfsr <= i_seed_value;
        end else if (i_cmd.start_draw) begin
            r_lfsr <= lfsr_advance(r_lfsr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_draw) begin
            r_bound <= i_range_max;
            r_shift <= shift_of(i_range_max);
        end
        if (i_cmd.clear_value) begin
            r_rem <= '0;
        end else if (i_cmd.prep) begin
            r_rem <= '0;
            r_quo <= r_lfsr >> r_shift;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            // restore unless the trial remainder reaches the bound
            r_rem <= n_diff[WORD_W] ? n_trial[WORD_W-1:0] : n_diff[WORD_W-1:0];
            r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_stat.is_load  = (i_func == FUNC_LOAD);
    assign o_stat.is_small = (i_range_max < MIN_BOUND);
    assign o_stat.div_last = (r_cnt == CNT_LAST);
    assign o_value         = r_rem;
    assign o_seed_now      = r_lfsr;

    a_rem_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && o_stat.div_last) |=> (r_rem < r_bound))
        else $error("remainder not below bound");

    a_seed_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_seed |=> (r_lfsr == $past(i_seed_value) && r_rem == '0))
        else $error("seed load lost");

endmodule

// ===== src/lfsr_bounded_random_top.sv =====
// Bounded random generator built on a 32-bit Galois LFSR (taps 0xd0000001,
// shift right, XOR taps when the old low bit is 1; reset state 1). Each
// request yields exactly one result. A draw request (func 0) with a bound of
// 2 or more steps the LFSR once, shifts the new state right by
// (32 - bitlength(bound)) / 2 and returns that value modulo the bound; a
// bound of 0 or 1 returns 0 and leaves the state alone. A load request
// (func 1) replaces the state with the seed and returns 0. Every result also
// carries the state after the request, so it can be saved and loaded later.
// An all-zero seed stays zero. One request is handled at a time: for a draw,
// the accepting edge steps the LFSR and sizes the shift, the prep state forms
// the dividend and the divide state runs the restoring divider that reduces
// it to the remainder; a load or a small bound presents its result the cycle
// after acceptance. The next request is taken the cycle after the result is
// accepted.
module lfsr_bounded_random_top
    import lbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_func,
    input  logic [WORD_W-1:0] i_range_max,
    input  logic [WORD_W-1:0] i_seed_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [WORD_W-1:0] o_value,
    output logic [WORD_W-1:0] o_seed_now
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequence each request: accept, set up and divide for a draw, hold the result.
    lbr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // Hold the LFSR state, the shift amount and the remainder divider.
    lbr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_func       (i_func),
        .i_range_max  (i_range_max),
        .i_seed_value (i_seed_value),
        .o_stat       (w_stat),
        .o_value      (o_value),
        .o_seed_now   (o_seed_now)
    );

    // Results only appear while no new request can enter.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("request accepted while result pending");

    // A request that is taken always leaves the input side closed next cycle.
    a_accept_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input stayed open after accepting a request");

endmodule
